// File: rtl/gslm_pkg.sv
package gslm_pkg;

   localparam int CFG_BITS       = 11;
   localparam int CSR_INDEX_BITS = 2;
   localparam int COUNT_BITS     = 21;
   localparam int INC_BITS       = 3;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd1024;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // where an item sits in the frame
   typedef struct packed {
      logic c_ge1;
      logic c_ge2;
      logic c_last;
      logic r_ge1;
      logic r_ge2;
      logic r_last;
   } pos_type;

   // decisions made for one item
   typedef struct packed {
      logic                valid;
      logic                last_item;
      logic [INC_BITS-1:0] inc;
   } dec_type;

endpackage

// File: rtl/gslm_ram.sv
module gslm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/gslm_window.sv
module gslm_window #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [2:0][PIXEL_BITS-1:0] column,
   input  gslm_pkg::pos_type          pos,
   output gslm_pkg::dec_type          dec
);

   // window indexed [column][row]; column 0 is the newest, row 2 the newest row
   logic [2:0][2:0][PIXEL_BITS-1:0] win_ff;
   gslm_pkg::pos_type               pos_ff;
   logic                            s2_valid_ff;
   gslm_pkg::dec_type               dec_ff;

   logic                              d_mid, d_mid_edge, d_bot, d_bot_edge;
   logic [gslm_pkg::INC_BITS-1:0]     inc_in;

   function automatic logic is_min(input logic [2:0][2:0][PIXEL_BITS-1:0] win,
                                   input int cc, input int rr,
                                   input logic [2:0] colm, input logic [2:0] rowm);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (colm[i] && rowm[j] && !(i == cc && j == rr) && (win[i][j] <= win[cc][rr])) begin
               ok = 1'b0;
            end
         end
      end
      return ok;
   endfunction

   always_comb begin
      d_mid      = pos_ff.r_ge1 && pos_ff.c_ge1 &&
                   is_min(win_ff, 1, 1, {pos_ff.c_ge2, 1'b1, 1'b1}, {1'b1, 1'b1, pos_ff.r_ge2});
      d_mid_edge = pos_ff.r_ge1 && pos_ff.c_last &&
                   is_min(win_ff, 0, 1, {1'b0, pos_ff.c_ge1, 1'b1}, {1'b1, 1'b1, pos_ff.r_ge2});
      d_bot      = pos_ff.r_last && pos_ff.c_ge1 &&
                   is_min(win_ff, 1, 2, {pos_ff.c_ge2, 1'b1, 1'b1}, {1'b1, pos_ff.r_ge1, 1'b0});
      d_bot_edge = pos_ff.r_last && pos_ff.c_last &&
                   is_min(win_ff, 0, 2, {1'b0, pos_ff.c_ge1, 1'b1}, {1'b1, pos_ff.r_ge1, 1'b0});
      inc_in = {2'b00, d_mid} + {2'b00, d_mid_edge} + {2'b00, d_bot} + {2'b00, d_bot_edge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         dec_ff.valid  <= 1'b0;
      end else if (advance) begin
         s2_valid_ff   <= in_valid;
         dec_ff.valid  <= s2_valid_ff;
      end
      if (advance) begin
         dec_ff.inc       <= inc_in;
         dec_ff.last_item <= pos_ff.c_last && pos_ff.r_last;
         if (in_valid) begin
            win_ff[2] <= win_ff[1];
            win_ff[1] <= win_ff[0];
            win_ff[0] <= column;
            pos_ff    <= pos;
         end
      end
   end

   assign dec = dec_ff;

endmodule

// File: rtl/grid_strict_local_minimum_counter.sv
// Counts the strict 8-neighbour local minima of a raster-order frame, one pixel per
// clock. Neighbours outside the frame are ignored; a pixel with none counts. Frame
// width and height come from csr writes (0 acts as 1, values above the maximum are
// held at the maximum); a write restarts the frame. One item per pixel is accepted
// in every cycle, set by the single line memory that takes one read and one write
// each cycle; it holds the two previous rows and needs no clearing. The frame count
// leaves once the last pixel has passed the input, window and decision registers.
// Input is held off only while a finished count waits behind an earlier, untaken one.
module grid_strict_local_minimum_counter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [PIXEL_BITS-1:0]               req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gslm_pkg::COUNT_BITS-1:0]     rsp_minimum_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gslm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gslm_pkg::CFG_BITS-1:0]       csr_data
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   function automatic logic [CW-1:0] width_last(input logic [gslm_pkg::CFG_BITS-1:0] v);
      int unsigned n;
      n = 32'(v);
      if (n == 0) n = 1;
      if (n > MAX_WIDTH) n = MAX_WIDTH;
      return CW'(n - 1);
   endfunction

   function automatic logic [RW-1:0] height_last(input logic [gslm_pkg::CFG_BITS-1:0] v);
      int unsigned n;
      n = 32'(v);
      if (n == 0) n = 1;
      if (n > MAX_HEIGHT) n = MAX_HEIGHT;
      return RW'(n - 1);
   endfunction

   logic [CW-1:0]                  wlast_ff, col_ff, s1_col_ff;
   logic [RW-1:0]                  hlast_ff, row_ff;
   logic [gslm_pkg::COUNT_BITS-1:0] count_ff, count_sum, rsp_count_ff;
   logic                           s1_valid_ff, byp_ff, rsp_valid_ff;
   logic [PIXEL_BITS-1:0]          s1_pixel_ff, byp_a_ff, byp_b_ff, cur_a, cur_b;
   gslm_pkg::pos_type              s1_pos_ff, pos_in;
   gslm_pkg::dec_type              dec;
   logic [2*PIXEL_BITS-1:0]        rd_data;
   logic [2:0][PIXEL_BITS-1:0]     column;
   logic                           adv, accept, csr_hit;

   assign adv       = !(dec.valid && dec.last_item && rsp_valid_ff && !rsp_ready);
   assign accept    = req_valid && adv;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && csr_ready &&
                      (csr_index inside {gslm_pkg::CSR_FRAME_WIDTH, gslm_pkg::CSR_FRAME_HEIGHT});

   assign cur_a  = byp_ff ? byp_a_ff : rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
   assign cur_b  = byp_ff ? byp_b_ff : rd_data[PIXEL_BITS-1:0];
   assign column = {s1_pixel_ff, cur_a, cur_b};
   assign count_sum = count_ff + gslm_pkg::COUNT_BITS'(dec.inc);

   always_comb begin
      pos_in.c_ge1  = col_ff != '0;
      pos_in.c_ge2  = col_ff > CW'(1);
      pos_in.c_last = col_ff == wlast_ff;
      pos_in.r_ge1  = row_ff != '0;
      pos_in.r_ge2  = row_ff > RW'(1);
      pos_in.r_last = row_ff == hlast_ff;
   end

   // line memory entry per column: {row above, row two above}
   gslm_ram #(
      .WIDTH (2 * PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff && adv),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_pixel_ff, cur_a}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   gslm_window #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv),
      .in_valid (s1_valid_ff),
      .column   (column),
      .pos      (s1_pos_ff),
      .dec      (dec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff     <= width_last(gslm_pkg::CFG_RESET);
         hlast_ff     <= height_last(gslm_pkg::CFG_RESET);
         col_ff       <= '0;
         row_ff       <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (pos_in.c_last) begin
               col_ff <= '0;
               row_ff <= pos_in.r_last ? '0 : row_ff + RW'(1);
            end else begin
               col_ff <= col_ff + CW'(1);
            end
            // single-column frame: same entry read while the previous item writes it
            byp_ff <= s1_valid_ff && (col_ff == s1_col_ff);
         end
         if (adv) begin
            s1_valid_ff <= accept;
            if (dec.valid) begin
               count_ff <= dec.last_item ? '0 : count_sum;
            end
         end
         if (adv && dec.valid && dec.last_item) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gslm_pkg::CSR_FRAME_WIDTH: begin
                  wlast_ff <= width_last(csr_data);
               end
               gslm_pkg::CSR_FRAME_HEIGHT: begin
                  hlast_ff <= height_last(csr_data);
               end
               default: begin
               end
            endcase
         end
         if (csr_hit) begin
            col_ff   <= '0;
            row_ff   <= '0;
            count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_ff;
         s1_pos_ff   <= pos_in;
         byp_a_ff    <= s1_pixel_ff;
         byp_b_ff    <= cur_a;
      end
      if (adv && dec.valid && dec.last_item) begin
         rsp_count_ff <= count_sum;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_minimum_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_bypass_only_single_column: assert property (@(posedge clock) disable iff (reset)
      accept && s1_valid_ff && (col_ff == s1_col_ff) |-> (wlast_ff == '0))
      else $error("line memory bypass with more than one column");

   a_position_in_frame: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= wlast_ff) && (row_ff <= hlast_ff))
      else $error("position outside frame");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      adv && dec.valid && dec.last_item |=> rsp_valid_ff && (count_ff == '0))
      else $error("frame end did not post count or clear");
`endif

endmodule
